// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the packer rtl
// include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GHPP_ASSERT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion %m failed");

// next-cycle implication
`define GHPP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion %m failed");

`endif

// ===== rtl/core/ghpp_pkg.sv =====
// types, codes and constants of the gray halftone pixel packer
// no dependencies
`timescale 1ns / 1ps

package ghpp_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int COEF_W  = 9;
  localparam int NOISE_W = 31;
  localparam int QUO_W   = 10;

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_PIXEL = 2'd1;
  localparam action_t ACT_EOL   = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_COEF_RED   = 3'd0;
  localparam reg_idx_t REG_COEF_GREEN = 3'd1;
  localparam reg_idx_t REG_COEF_BLUE  = 3'd2;
  localparam reg_idx_t REG_COEF_ALPHA = 3'd3;
  localparam reg_idx_t REG_BITS_CODE  = 3'd4;
  localparam reg_idx_t REG_DITHER_AMP = 3'd5;

  localparam logic [COEF_W-1:0] COEF_RED_RST   = 9'd77;
  localparam logic [COEF_W-1:0] COEF_GREEN_RST = 9'd151;
  localparam logic [COEF_W-1:0] COEF_BLUE_RST  = 9'd28;
  localparam logic [COEF_W-1:0] COEF_ALPHA_RST = 9'd0;
  localparam logic [1:0]        BITS_CODE_RST  = 2'd3;
  localparam logic [7:0]        DITHER_AMP_RST = 8'd0;

  localparam logic [NOISE_W-1:0] NOISE_HALF_RANGE = 31'h4000_0000;

  typedef struct packed {
    logic [COEF_W-1:0] coef_red;
    logic [COEF_W-1:0] coef_green;
    logic [COEF_W-1:0] coef_blue;
    logic [COEF_W-1:0] coef_alpha;
    logic [1:0]        bits_code;
    logic [7:0]        dither_amp;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TBL_WR,
    ST_MUL,
    ST_SUM,
    ST_TBL_RD,
    ST_DIV_AMP_GO,
    ST_DIV_AMP,
    ST_DIV_NOISE_GO,
    ST_DIV_NOISE,
    ST_DITHER,
    ST_PACK,
    ST_EOL
  } state_t;

  typedef enum logic {
    DIV_SEL_AMP,
    DIV_SEL_NOISE
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     tbl_wr;
    logic     mul;
    logic     sum;
    logic     div_start;
    div_sel_t div_sel;
    logic     divisor_ld;
    logic     quo_ld;
    logic     gray_ld;
    logic     pack;
    logic     eol;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dither_on;
    logic divisor_ok;
    logic div_busy;
    logic pack_emit;
    logic eol_empty;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/ghpp_ifs.sv =====
// valid/ready channel interfaces for pixel items and packed bytes
// depends on ghpp_pkg
`timescale 1ns / 1ps

interface ghpp_in_if;
  logic                          valid;
  logic                          ready;
  ghpp_pkg::action_t             action;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;
  logic [7:0]                    alpha;
  logic [7:0]                    table_index;
  logic [7:0]                    table_value;
  logic [ghpp_pkg::NOISE_W-1:0]  noise;

  modport source (
    output valid, action, red, green, blue, alpha, table_index, table_value, noise,
    input  ready
  );
  modport sink (
    input  valid, action, red, green, blue, alpha, table_index, table_value, noise,
    output ready
  );
endinterface

interface ghpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       line_end;

  modport source (
    output valid, packed_byte, line_end,
    input  ready
  );
  modport sink (
    input  valid, packed_byte, line_end,
    output ready
  );
endinterface

// ===== rtl/core/ghpp_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on ghpp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghpp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ghpp_pkg::NOISE_W-1:0] dividend,
  input  logic [ghpp_pkg::NOISE_W-1:0] divisor,
  output logic                         busy,
  output logic [ghpp_pkg::NOISE_W-1:0] quotient
);

  localparam int W     = ghpp_pkg::NOISE_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dq;
  logic [W-1:0]     dvs;
  logic [W-1:0]     rem;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial    = {rem, dq[W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        dq  <= {dq[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        dq  <= {dq[W-2:0], 1'b0};
      end
    end
  end

  `GHPP_ASSERT_NEXT(div_keeps_running, clk, rst, busy && (cnt != CNT_W'(1)) && !start, busy)

endmodule

// ===== rtl/core/ghpp_dp.sv =====
// datapath: luminance, intensity table, dither, quantize and byte packing
// depends on ghpp_pkg, ghpp_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghpp_dp #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ghpp_pkg::cfg_t               cfg,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  input  logic [7:0]                   alpha,
  input  logic [7:0]                   table_index,
  input  logic [7:0]                   table_value,
  input  logic [ghpp_pkg::NOISE_W-1:0] noise,
  input  ghpp_pkg::ctrl_cmd_t          cmd,
  output ghpp_pkg::dp_status_t         st,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [7:0]                   packed_byte,
  output logic                         line_end
);

  localparam int PVMAX = (1 << PIXEL_BITS) - 1;
  localparam int GW    = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;
  localparam int NW    = ghpp_pkg::NOISE_W;
  localparam int QW    = ghpp_pkg::QUO_W;

  logic [7:0]    r_q, g_q, b_q, a_q;
  logic [7:0]    tidx_q, tval_q;
  logic [NW-1:0] noise_q;
  logic [16:0]   prod_r, prod_g, prod_b, prod_a;
  logic [18:0]   lum_sum;
  logic [10:0]   lum;
  logic [7:0]    gidx;
  logic [7:0]    gidx_next;
  logic [7:0]    tbl [256];
  logic [7:0]    tbl_q;

  logic          div_start;
  logic          div_busy;
  logic [NW-1:0] div_dividend;
  logic [NW-1:0] div_divisor;
  logic [NW-1:0] div_quotient;
  logic [NW-1:0] divisor;
  logic          div_ok;
  logic [7:0]    amp_cached;
  logic [QW-1:0] quo;

  logic signed [13:0] dith_sum;
  logic [GW-1:0]      gray;
  logic [GW-1:0]      gray_next;

  logic [3:0]  nbits;
  logic [31:0] g32;
  logic [31:0] q32;
  logic [7:0]  qmask;
  logic [7:0]  qbits;
  logic [7:0]  acc;
  logic [7:0]  acc_next;
  logic [3:0]  cnt;
  logic [3:0]  cnt_sum;
  logic [7:0]  pad_byte;
  logic        pack_emit;
  logic        eol_empty;
  logic        load_out;

  // capture of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_q     <= red;
      g_q     <= green;
      b_q     <= blue;
      a_q     <= alpha;
      tidx_q  <= table_index;
      tval_q  <= table_value;
      noise_q <= noise;
    end
  end

  // weighted luminance
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= 17'(cfg.coef_red)   * 17'(r_q);
      prod_g <= 17'(cfg.coef_green) * 17'(g_q);
      prod_b <= 17'(cfg.coef_blue)  * 17'(b_q);
      prod_a <= 17'(cfg.coef_alpha) * 17'(a_q);
    end
  end

  assign lum_sum = 19'(prod_r) + 19'(prod_g) + 19'(prod_b) + 19'(prod_a);
  assign lum     = lum_sum[18:8];

  always_comb begin
    if ({21'd0, lum} > 32'(PVMAX)) begin
      gidx_next = 8'(PVMAX);
    end else begin
      gidx_next = lum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      gidx <= gidx_next;
    end
  end

  // intensity table
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl[tidx_q] <= tval_q;
    end
    tbl_q <= tbl[gidx];
  end

  // dither divisions on a shared divider
  assign div_start    = cmd.div_start;
  assign div_dividend = (cmd.div_sel == ghpp_pkg::DIV_SEL_AMP) ?
                        ghpp_pkg::NOISE_HALF_RANGE : noise_q;
  assign div_divisor  = (cmd.div_sel == ghpp_pkg::DIV_SEL_AMP) ?
                        NW'(cfg.dither_amp) : divisor;

  ghpp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      div_ok <= 1'b0;
    end else if (cmd.divisor_ld) begin
      div_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.divisor_ld) begin
      divisor    <= div_quotient;
      amp_cached <= cfg.dither_amp;
    end
    if (cmd.quo_ld) begin
      quo <= div_quotient[QW-1:0];
    end
  end

  assign dith_sum = $signed({6'd0, tbl_q}) + $signed({4'd0, quo})
                  - $signed({6'd0, cfg.dither_amp});

  always_comb begin
    if (cfg.dither_amp == 8'd0) begin
      gray_next = GW'(tbl_q);
    end else if (dith_sum < 0) begin
      gray_next = '0;
    end else if (int'(dith_sum) > PVMAX) begin
      gray_next = GW'(PVMAX);
    end else begin
      gray_next = GW'(dith_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gray_ld) begin
      gray <= gray_next;
    end
  end

  // quantize and pack msb first
  assign nbits = 4'd1 << cfg.bits_code;
  assign g32   = 32'(gray);
  assign qmask = 8'((9'd1 << nbits) - 9'd1);

  always_comb begin
    if (PIXEL_BITS >= int'(nbits)) begin
      q32 = g32 >> (PIXEL_BITS - int'(nbits));
    end else begin
      q32 = g32 << (int'(nbits) - PIXEL_BITS);
    end
  end

  assign qbits     = q32[7:0] & qmask;
  assign acc_next  = 8'((16'(acc) << nbits) | 16'(qbits));
  assign cnt_sum   = cnt + nbits;
  assign pack_emit = cnt_sum[3];
  assign eol_empty = (cnt == 4'd0);
  assign pad_byte  = 8'(16'(acc) << (4'd8 - cnt));
  assign load_out  = (cmd.pack && pack_emit) || (cmd.eol && !eol_empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.pack) begin
      if (pack_emit) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_next;
        cnt <= cnt_sum;
      end
    end else if (cmd.eol) begin
      acc <= '0;
      cnt <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack && pack_emit) begin
      packed_byte <= acc_next;
      line_end    <= 1'b0;
    end else if (cmd.eol && !eol_empty) begin
      packed_byte <= pad_byte;
      line_end    <= 1'b1;
    end
  end

  assign st.dither_on  = (cfg.dither_amp != 8'd0);
  assign st.divisor_ok = div_ok && (amp_cached == cfg.dither_amp);
  assign st.div_busy   = div_busy;
  assign st.pack_emit  = pack_emit;
  assign st.eol_empty  = eol_empty;
  assign st.out_busy   = out_valid && !out_ready;

  `GHPP_ASSERT(dp_no_overwrite, clk, rst, out_valid && !out_ready, !load_out)
  `GHPP_ASSERT(dp_cnt_partial, clk, rst, 1'b1, cnt < 4'd8)

endmodule

// ===== rtl/core/ghpp_ctrl.sv =====
// controller state machine sequencing the datapath per transaction
// depends on ghpp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghpp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ghpp_pkg::action_t    in_action,
  output logic                 in_ready,
  input  ghpp_pkg::dp_status_t st,
  output ghpp_pkg::ctrl_cmd_t  cmd
);

  ghpp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ghpp_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ghpp_pkg::ACT_LOAD:  state_next = ghpp_pkg::ST_TBL_WR;
            ghpp_pkg::ACT_PIXEL: state_next = ghpp_pkg::ST_MUL;
            ghpp_pkg::ACT_EOL:   state_next = ghpp_pkg::ST_EOL;
            default:             state_next = ghpp_pkg::ST_IDLE;
          endcase
        end
      end
      ghpp_pkg::ST_TBL_WR: state_next = ghpp_pkg::ST_IDLE;
      ghpp_pkg::ST_MUL:    state_next = ghpp_pkg::ST_SUM;
      ghpp_pkg::ST_SUM:    state_next = ghpp_pkg::ST_TBL_RD;
      ghpp_pkg::ST_TBL_RD: begin
        if (!st.dither_on) begin
          state_next = ghpp_pkg::ST_DITHER;
        end else if (st.divisor_ok) begin
          state_next = ghpp_pkg::ST_DIV_NOISE_GO;
        end else begin
          state_next = ghpp_pkg::ST_DIV_AMP_GO;
        end
      end
      ghpp_pkg::ST_DIV_AMP_GO: state_next = ghpp_pkg::ST_DIV_AMP;
      ghpp_pkg::ST_DIV_AMP: begin
        if (!st.div_busy) begin
          state_next = ghpp_pkg::ST_DIV_NOISE_GO;
        end
      end
      ghpp_pkg::ST_DIV_NOISE_GO: state_next = ghpp_pkg::ST_DIV_NOISE;
      ghpp_pkg::ST_DIV_NOISE: begin
        if (!st.div_busy) begin
          state_next = ghpp_pkg::ST_DITHER;
        end
      end
      ghpp_pkg::ST_DITHER: state_next = ghpp_pkg::ST_PACK;
      ghpp_pkg::ST_PACK: begin
        if (!(st.pack_emit && st.out_busy)) begin
          state_next = ghpp_pkg::ST_IDLE;
        end
      end
      ghpp_pkg::ST_EOL: begin
        if (st.eol_empty || !st.out_busy) begin
          state_next = ghpp_pkg::ST_IDLE;
        end
      end
      default: state_next = ghpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ghpp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ghpp_pkg::ST_TBL_WR: cmd.tbl_wr = 1'b1;
      ghpp_pkg::ST_MUL:    cmd.mul    = 1'b1;
      ghpp_pkg::ST_SUM:    cmd.sum    = 1'b1;
      ghpp_pkg::ST_DIV_AMP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ghpp_pkg::DIV_SEL_AMP;
      end
      ghpp_pkg::ST_DIV_AMP: cmd.divisor_ld = !st.div_busy;
      ghpp_pkg::ST_DIV_NOISE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ghpp_pkg::DIV_SEL_NOISE;
      end
      ghpp_pkg::ST_DIV_NOISE: cmd.quo_ld  = !st.div_busy;
      ghpp_pkg::ST_DITHER:    cmd.gray_ld = 1'b1;
      ghpp_pkg::ST_PACK:      cmd.pack    = !(st.pack_emit && st.out_busy);
      ghpp_pkg::ST_EOL:       cmd.eol     = !st.eol_empty && !st.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  `GHPP_ASSERT(ctrl_start_when_free, clk, rst, cmd.div_start, !st.div_busy)
  `GHPP_ASSERT(ctrl_divisor_current, clk, rst, cmd.quo_ld, st.divisor_ok)

endmodule

// ===== rtl/core/gray_halftone_pixel_packer.sv =====
// load and end-of-line transactions run one state each, a pixel runs mul, sum,
// table read, dither and pack; a dithered pixel adds a division in the 31-step
// serial divider, and the first after reset or a new dither_amp runs two divisions
// the output byte register lets the next transaction in while a byte waits
// rst is synchronous, active high: clears control, loads register defaults
// intensity table contents are undefined until loaded
`timescale 1ns / 1ps

module gray_halftone_pixel_packer #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  ghpp_in_if.sink                       item,
  ghpp_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ghpp_pkg::ADDR_W-1:0]   paddr,
  input  logic [ghpp_pkg::DATA_W-1:0]   pwdata,
  output logic [ghpp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  ghpp_pkg::cfg_t       cfg;
  ghpp_pkg::reg_idx_t   reg_idx;
  ghpp_pkg::ctrl_cmd_t  cmd;
  ghpp_pkg::dp_status_t st;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ghpp_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_red   <= ghpp_pkg::COEF_RED_RST;
      cfg.coef_green <= ghpp_pkg::COEF_GREEN_RST;
      cfg.coef_blue  <= ghpp_pkg::COEF_BLUE_RST;
      cfg.coef_alpha <= ghpp_pkg::COEF_ALPHA_RST;
      cfg.bits_code  <= ghpp_pkg::BITS_CODE_RST;
      cfg.dither_amp <= ghpp_pkg::DITHER_AMP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        ghpp_pkg::REG_COEF_RED:   cfg.coef_red   <= pwdata[ghpp_pkg::COEF_W-1:0];
        ghpp_pkg::REG_COEF_GREEN: cfg.coef_green <= pwdata[ghpp_pkg::COEF_W-1:0];
        ghpp_pkg::REG_COEF_BLUE:  cfg.coef_blue  <= pwdata[ghpp_pkg::COEF_W-1:0];
        ghpp_pkg::REG_COEF_ALPHA: cfg.coef_alpha <= pwdata[ghpp_pkg::COEF_W-1:0];
        ghpp_pkg::REG_BITS_CODE:  cfg.bits_code  <= pwdata[1:0];
        ghpp_pkg::REG_DITHER_AMP: cfg.dither_amp <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ghpp_pkg::REG_COEF_RED:   prdata = ghpp_pkg::DATA_W'(cfg.coef_red);
      ghpp_pkg::REG_COEF_GREEN: prdata = ghpp_pkg::DATA_W'(cfg.coef_green);
      ghpp_pkg::REG_COEF_BLUE:  prdata = ghpp_pkg::DATA_W'(cfg.coef_blue);
      ghpp_pkg::REG_COEF_ALPHA: prdata = ghpp_pkg::DATA_W'(cfg.coef_alpha);
      ghpp_pkg::REG_BITS_CODE:  prdata = ghpp_pkg::DATA_W'(cfg.bits_code);
      ghpp_pkg::REG_DITHER_AMP: prdata = ghpp_pkg::DATA_W'(cfg.dither_amp);
      default:                  prdata = '0;
    endcase
  end

  ghpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_action (item.action),
    .in_ready  (item.ready),
    .st        (st),
    .cmd       (cmd)
  );

  ghpp_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .red         (item.red),
    .green       (item.green),
    .blue        (item.blue),
    .alpha       (item.alpha),
    .table_index (item.table_index),
    .table_value (item.table_value),
    .noise       (item.noise),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .packed_byte (result.packed_byte),
    .line_end    (result.line_end)
  );

endmodule
